/* src/rbht_pkg.sv */
package rbht_pkg;

  localparam int NUM_RELAYS = 14;
  localparam int IDX_W      = $clog2(NUM_RELAYS);
  localparam int HOLE_AFTER = 6;
  localparam int BITMAP_W   = 15;
  localparam int BM_IDX_W   = $clog2(BITMAP_W);

  localparam logic [2:0] CMD_CLAIM   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_SET     = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_COMMIT  = 3'd4;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_INVALID    = 3'd1;
  localparam logic [2:0] STS_CLAIMED    = 3'd2;
  localparam logic [2:0] STS_NOTCLAIMED = 3'd3;
  localparam logic [2:0] STS_WAIT       = 3'd4;
  localparam logic [2:0] STS_OFFLINE    = 3'd5;

  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_OFF  = 2'd2;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        borrow;
  } alu_rsp_t;

endpackage

/* src/relay_bank_hold_time_accounting_core.sv */
// claim, release, query, invalid and offline words go from S_CMD to S_FIN; a set request that changes state adds
// S_HOLD and, if refused, S_REM; commit visits S_CE for each of the 14 relays, S_CACC on a change, S_CCNT on one to on
// throughput: one word at a time; the next word is taken the cycle after the result is loaded
// all time and count arithmetic runs through one shared 32-bit add/subtract unit, which sets the per-relay cost
// reset: synchronous active-high rst clears every relay entry, online_enable and the handshakes
module relay_bank_hold_time_accounting_core
  import rbht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic [3:0]          relay_id,
  input  logic                want_on,
  input  logic [31:0]         min_hold,
  input  logic [31:0]         now_seconds,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [31:0]         remaining_wait,
  output logic                relay_is_on,
  output logic [31:0]         state_seconds,
  output logic [31:0]         on_total,
  output logic [31:0]         off_total,
  output logic [31:0]         cycle_count,
  output logic [BITMAP_W-1:0] relay_bitmap,
  output logic [1:0]          change_kind
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_HOLD = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_CE   = 3'd4;
  localparam logic [2:0] S_CACC = 3'd5;
  localparam logic [2:0] S_CCNT = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state;
  logic       online_enable;

  logic [NUM_RELAYS-1:0] claimed;
  logic [NUM_RELAYS-1:0] requested_on;
  logic [NUM_RELAYS-1:0] actual_on;
  logic [31:0] on_stamp      [NUM_RELAYS];
  logic [31:0] off_stamp     [NUM_RELAYS];
  logic [31:0] time_in_state [NUM_RELAYS];
  logic [31:0] on_accum      [NUM_RELAYS];
  logic [31:0] off_accum     [NUM_RELAYS];
  logic [31:0] switch_cycles [NUM_RELAYS];

  logic [2:0]       kind_q;
  logic             want_q;
  logic [31:0]      hold_q;
  logic [31:0]      now_q;
  logic             id_ok;
  logic [IDX_W-1:0] idx;
  logic [31:0]      tmp;
  logic             going_on;
  logic             add_ok;

  logic [2:0]          res_status;
  logic [31:0]         res_wait;
  logic                res_on;
  logic [31:0]         res_state;
  logic [31:0]         res_on_tot;
  logic [31:0]         res_off_tot;
  logic [31:0]         res_cycles;
  logic [BITMAP_W-1:0] res_bitmap;
  logic [1:0]          res_change;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [31:0]  since_cur;
  logic [IDX_W:0] pos;
  logic         last;

  rbht_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign since_cur = actual_on[idx] ? on_stamp[idx] : off_stamp[idx];
  assign last      = (idx == IDX_W'(NUM_RELAYS - 1));
  assign pos       = (idx > IDX_W'(HOLE_AFTER)) ? ({1'b0, idx} + (IDX_W + 1)'(1)) : {1'b0, idx};

  always_comb begin
    alu_req.a   = now_q;
    alu_req.b   = since_cur;
    alu_req.sub = 1'b1;
    case (state)
      S_HOLD: begin
        alu_req.a = tmp;
        alu_req.b = hold_q;
      end
      S_REM: begin
        alu_req.a = hold_q;
        alu_req.b = tmp;
      end
      S_CACC: begin
        alu_req.a   = going_on ? off_accum[idx] : on_accum[idx];
        alu_req.b   = tmp;
        alu_req.sub = 1'b0;
      end
      S_CCNT: begin
        alu_req.a   = switch_cycles[idx];
        alu_req.b   = 32'd1;
        alu_req.sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      online_enable <= 1'b0;
      out_valid     <= 1'b0;
      claimed       <= '0;
      requested_on  <= '0;
      actual_on     <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        on_stamp[i]      <= '0;
        off_stamp[i]     <= '0;
        time_in_state[i] <= '0;
        on_accum[i]      <= '0;
        off_accum[i]     <= '0;
        switch_cycles[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        online_enable <= cfg_data;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q      <= kind;
            want_q      <= want_on;
            hold_q      <= min_hold;
            now_q       <= now_seconds;
            id_ok       <= (relay_id != 4'd0) && (32'(relay_id) <= 32'(NUM_RELAYS));
            idx         <= IDX_W'({1'b0, relay_id} - 5'd1);
            res_wait    <= '0;
            res_on      <= 1'b0;
            res_state   <= '0;
            res_on_tot  <= '0;
            res_off_tot <= '0;
            res_cycles  <= '0;
            res_bitmap  <= '0;
            res_change  <= CHG_NONE;
            state       <= S_CMD;
          end
        end
        S_CMD: begin
          if (kind_q == CMD_COMMIT) begin
            if (!online_enable) begin
              res_status <= STS_OFFLINE;
              state      <= S_FIN;
            end else begin
              res_status <= STS_OK;
              idx        <= '0;
              state      <= S_CE;
            end
          end else if (!id_ok || kind_q > CMD_COMMIT) begin
            res_status <= STS_INVALID;
            state      <= S_FIN;
          end else if (kind_q == CMD_CLAIM) begin
            state <= S_FIN;
            if (claimed[idx]) begin
              res_status <= STS_CLAIMED;
            end else begin
              res_status   <= STS_OK;
              claimed[idx] <= 1'b1;
            end
          end else if (!claimed[idx]) begin
            res_status <= STS_NOTCLAIMED;
            state      <= S_FIN;
          end else begin
            res_status <= STS_OK;
            case (kind_q)
              CMD_RELEASE: begin
                claimed[idx]       <= 1'b0;
                requested_on[idx]  <= 1'b0;
                actual_on[idx]     <= 1'b0;
                on_stamp[idx]      <= '0;
                off_stamp[idx]     <= '0;
                time_in_state[idx] <= '0;
                on_accum[idx]      <= '0;
                off_accum[idx]     <= '0;
                switch_cycles[idx] <= '0;
                state              <= S_FIN;
              end
              CMD_SET: begin
                if (want_q != actual_on[idx]) begin
                  tmp   <= alu_rsp.sum;
                  state <= S_HOLD;
                end else begin
                  state <= S_FIN;
                end
              end
              default: begin
                time_in_state[idx] <= alu_rsp.sum;
                res_state          <= alu_rsp.sum;
                res_on             <= actual_on[idx];
                res_on_tot         <= on_accum[idx];
                res_off_tot        <= off_accum[idx];
                res_cycles         <= switch_cycles[idx];
                state              <= S_FIN;
              end
            endcase
          end
        end
        S_HOLD: begin
          if (alu_rsp.borrow) begin
            state <= S_REM;
          end else begin
            requested_on[idx] <= want_q;
            state             <= S_FIN;
          end
        end
        S_REM: begin
          res_status <= STS_WAIT;
          res_wait   <= alu_rsp.sum;
          state      <= S_FIN;
        end
        S_CE: begin
          if (claimed[idx] && requested_on[idx] && pos < (IDX_W + 1)'(BITMAP_W)) begin
            res_bitmap[pos[BM_IDX_W-1:0]] <= 1'b1;
          end
          if (claimed[idx] && (requested_on[idx] != actual_on[idx])) begin
            // state change: measure the old state, then fold it into its total
            tmp                <= alu_rsp.sum;
            add_ok             <= (since_cur != 32'd0);
            going_on           <= requested_on[idx];
            actual_on[idx]     <= requested_on[idx];
            time_in_state[idx] <= '0;
            state              <= S_CACC;
            if (requested_on[idx]) begin
              on_stamp[idx]  <= now_q;
              off_stamp[idx] <= '0;
              res_change     <= CHG_ON;
            end else begin
              off_stamp[idx] <= now_q;
              on_stamp[idx]  <= '0;
              res_change     <= CHG_OFF;
            end
          end else begin
            if (claimed[idx]) begin
              time_in_state[idx] <= alu_rsp.sum;
            end
            if (last) begin
              state <= S_FIN;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_CACC: begin
          if (add_ok) begin
            if (going_on) begin
              off_accum[idx] <= alu_rsp.sum;
            end else begin
              on_accum[idx] <= alu_rsp.sum;
            end
          end
          if (going_on) begin
            state <= S_CCNT;
          end else if (last) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_CE;
          end
        end
        S_CCNT: begin
          switch_cycles[idx] <= alu_rsp.sum;
          if (last) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_CE;
          end
        end
        default: begin
          if (!out_valid || out_ready) begin
            status         <= res_status;
            remaining_wait <= res_wait;
            relay_is_on    <= res_on;
            state_seconds  <= res_state;
            on_total       <= res_on_tot;
            off_total      <= res_off_tot;
            cycle_count    <= res_cycles;
            relay_bitmap   <= res_bitmap;
            change_kind    <= res_change;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

  // only claimed relays can be requested or driven on
  a_flags_claimed: assert property (@(posedge clk) disable iff (rst)
    ((actual_on | requested_on) & ~claimed) == '0)
    else $error("relay state set on an unclaimed entry");

  // a refused request always leaves some wait
  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_WAIT) |-> (remaining_wait != 32'd0))
    else $error("must-wait word with zero remaining wait");

  // a new result word is only loaded from the finish step
  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == S_FIN))
    else $error("result word loaded outside finish step");

endmodule

/* src/rbht_alu.sv */
module rbht_alu
  import rbht_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] full;
  logic [31:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.sub};
  assign rsp.sum = full[31:0];
  // a below b when subtracting and no carry out
  assign rsp.borrow = req.sub & ~full[32];

endmodule
